>>> rtl/tpc_pkg.sv
// shared constants and types of the three point tangent and curvature unit
`default_nettype none

package tpc_pkg;

  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned TAN_W    = 16;
  localparam int unsigned CURV_W   = 32;
  localparam int unsigned STEP_W   = 16;

  // tangent: isqrt(floor(d^2 * 2^30 / q))
  localparam int unsigned TAN_SH   = 30;
  localparam int unsigned TAN_QW   = TAN_SH + 1;
  localparam int unsigned TAN_IW   = TAN_QW + 1;

  // curvature: isqrt(floor(na^2 * 2^46 / q^3)), quotient capped at 64 bits
  localparam int unsigned CURV_SH  = 46;
  localparam int unsigned CURV_QW  = 64;
  localparam int unsigned CURV_LO  = CURV_QW - CURV_SH;

  localparam logic [CURV_W-1:0] CURV_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [CURV_W-1:0] CURV_NEG_MAG = 32'h8000_0000;

  typedef struct packed {
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic               neg_x;
    logic               neg_y;
    logic               neg_k;
    logic               zero;
    logic               sat;
  } side_t;

endpackage

`default_nettype wire

>>> rtl/tpc_in_if.sv
// input channel: three contour points per item
`default_nettype none

interface tpc_in_if import tpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] a_x;
  logic signed [FIELD_W-1:0] a_y;
  logic signed [FIELD_W-1:0] b_x;
  logic signed [FIELD_W-1:0] b_y;
  logic signed [FIELD_W-1:0] c_x;
  logic signed [FIELD_W-1:0] c_y;

  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, output ready);
endinterface

`default_nettype wire

>>> rtl/tpc_out_if.sv
// output channel: tangent, curvature and step length per item
`default_nettype none

interface tpc_out_if import tpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [TAN_W-1:0]   tan_x;
  logic signed [TAN_W-1:0]   tan_y;
  logic signed [CURV_W-1:0]  curvature;
  logic [STEP_W-1:0]         step_length;
  logic                      degenerate;

  modport source (output valid, pos_x, pos_y, tan_x, tan_y, curvature, step_length,
                  degenerate, input ready);
  modport sink   (input valid, pos_x, pos_y, tan_x, tan_y, curvature, step_length,
                  degenerate, output ready);
endinterface

`default_nettype wire

>>> rtl/tpc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module tpc_div import tpc_pkg::*; #(
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 31
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_in [QW];
  logic [QW-1:0] sh_in  [QW];
  logic [DW-1:0] den_in [QW];
  logic [DW-1:0] rem_q  [QW-1];
  logic [QW-1:0] sh_q   [QW];
  logic [DW-1:0] den_q  [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [DW:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = num_hi_i;
      assign sh_in[k]  = num_lo_i;
      assign den_in[k] = den_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign sh_in[k]  = sh_q[k-1];
      assign den_in[k] = den_q[k-1];
    end

    assign t  = {rem_in[k], sh_in[k][QW-1]};
    assign ge = t >= {1'b0, den_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sh_q[k] <= {sh_in[k][QW-2:0], ge};
      end
    end

    if (k < QW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? DW'(t - {1'b0, den_in[k]}) : t[DW-1:0];
          den_q[k] <= den_in[k];
        end
      end
    end
  end

  assign quo_o = sh_q[QW-1];

endmodule

`default_nettype wire

>>> rtl/tpc_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module tpc_isqrt import tpc_pkg::*; #(
  parameter int unsigned IW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IW-1:0]   val_i,
  output logic [IW/2-1:0] root_o
);

  localparam int unsigned OW = IW / 2;
  localparam int unsigned RW = OW + 1;

  logic [RW-1:0] rem_in  [OW];
  logic [OW-1:0] root_in [OW];
  logic [IW-1:0] sh_in   [OW];
  logic [RW-1:0] rem_q   [OW-1];
  logic [OW-1:0] root_q  [OW];
  logic [IW-1:0] sh_q    [OW-1];

  for (genvar k = 0; k < OW; k++) begin : g_stg
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign sh_in[k]   = val_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign sh_in[k]   = sh_q[k-1];
    end

    assign t     = {rem_in[k], sh_in[k][IW-1:IW-2]};
    assign trial = {1'b0, root_in[k], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[k][OW-2:0], ge};
      end
    end

    if (k < OW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? RW'(t - trial) : RW'(t);
          sh_q[k]  <= {sh_in[k][IW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[OW-1];

endmodule

`default_nettype wire

>>> rtl/three_point_tangent_curvature_unit.sv
// top level: unit tangent, step length and curvature from three contour points
//
//   channel  dir  handshake    payload
//   in_i     in   valid/ready  a_x a_y b_x b_y c_x c_y
//   out_o    out  valid/ready  pos_x pos_y tan_x tan_y curvature step_length degenerate
//
// one item per cycle while the output is not stalled, 103 register stages
// most of that depth is the 64-stage curvature divider and the 32-stage root behind it
// rst_ni clears the valid bits only, payload stages hold whatever they had
// a stalled output freezes the whole pipeline, ready drops while a result waits untaken
`default_nettype none

module three_point_tangent_curvature_unit import tpc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpc_in_if.sink    in_i,
  tpc_out_if.source out_o
);

  localparam int unsigned CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned DFW  = CW + 1;
  localparam int unsigned SDW  = CW + 3;
  localparam int unsigned PW   = DFW + SDW;
  localparam int unsigned SQW  = 2 * CW;
  localparam int unsigned QW   = 2 * CW + 1;
  localparam int unsigned NAW  = 2 * CW + 2;
  localparam int unsigned Q2W  = 2 * QW;
  localparam int unsigned Q3W  = 3 * QW;
  localparam int unsigned NSW  = 2 * NAW;
  localparam int unsigned SIW  = QW + 1;
  localparam int unsigned SOW  = SIW / 2;
  localparam int unsigned PRE  = 6;
  localparam int unsigned BODY = CURV_QW + CURV_QW / 2;
  localparam int unsigned LAT  = PRE + BODY + 1;
  localparam int unsigned TAN_DLY  = BODY - TAN_QW - TAN_IW / 2;
  localparam int unsigned STP_DLY  = BODY - SOW;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = out_o.ready | ~vld_q[LAT-1];
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // stage 1: differences
  logic signed [CW-1:0]  ax, ay, bx, by, cx, cy;
  logic signed [DFW-1:0] dx_q, dy_q;
  logic signed [SDW-1:0] ddx_q, ddy_q;
  side_t                 side1_d, side1_q;

  assign ax = in_i.a_x[CW-1:0];
  assign ay = in_i.a_y[CW-1:0];
  assign bx = in_i.b_x[CW-1:0];
  assign by = in_i.b_y[CW-1:0];
  assign cx = in_i.c_x[CW-1:0];
  assign cy = in_i.c_y[CW-1:0];

  always_comb begin
    side1_d       = '0;
    side1_d.pos_x = FIELD_W'(bx);
    side1_d.pos_y = FIELD_W'(by);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= DFW'(cx) - DFW'(ax);
      dy_q    <= DFW'(cy) - DFW'(ay);
      ddx_q   <= SDW'(ax) - (SDW'(bx) <<< 1) + SDW'(cx);
      ddy_q   <= SDW'(ay) - (SDW'(by) <<< 1) + SDW'(cy);
      side1_q <= side1_d;
    end
  end

  // stage 2: squares and cross products
  logic [CW-1:0]        dxa, dya;
  logic [SQW-1:0]       dxsq2_q, dysq2_q;
  logic signed [PW-1:0] cr1_q, cr2_q;
  side_t                side2_d, side2_q;

  assign dxa = dx_q[DFW-1] ? CW'(-dx_q) : CW'(dx_q);
  assign dya = dy_q[DFW-1] ? CW'(-dy_q) : CW'(dy_q);

  always_comb begin
    side2_d       = side1_q;
    side2_d.neg_x = dx_q[DFW-1];
    side2_d.neg_y = dy_q[DFW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxsq2_q <= SQW'(dxa) * SQW'(dxa);
      dysq2_q <= SQW'(dya) * SQW'(dya);
      cr1_q   <= PW'(dx_q) * PW'(ddy_q);
      cr2_q   <= PW'(dy_q) * PW'(ddx_q);
      side2_q <= side2_d;
    end
  end

  // stage 3: squared length and numerator magnitude
  logic signed [PW:0] num;
  logic [QW-1:0]      q3_q;
  logic [NAW-1:0]     na3_q;
  logic [SQW-1:0]     dxsq3_q, dysq3_q;
  side_t              side3_d, side3_q;

  assign num = (PW + 1)'(cr1_q) - (PW + 1)'(cr2_q);

  always_comb begin
    side3_d       = side2_q;
    side3_d.neg_k = num[PW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_q    <= QW'(dxsq2_q) + QW'(dysq2_q);
      na3_q   <= num[PW] ? NAW'(-num) : NAW'(num);
      dxsq3_q <= dxsq2_q;
      dysq3_q <= dysq2_q;
      side3_q <= side3_d;
    end
  end

  // stage 4: q^2 and na^2
  logic [QW-1:0]  q4_q;
  logic [Q2W-1:0] qq4_q;
  logic [NSW-1:0] nasq4_q;
  logic [SQW-1:0] dxsq4_q, dysq4_q;
  side_t          side4_d, side4_q;

  always_comb begin
    side4_d      = side3_q;
    side4_d.zero = (q3_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q4_q    <= q3_q;
      qq4_q   <= Q2W'(q3_q) * Q2W'(q3_q);
      nasq4_q <= NSW'(na3_q) * NSW'(na3_q);
      dxsq4_q <= dxsq3_q;
      dysq4_q <= dysq3_q;
      side4_q <= side4_d;
    end
  end

  // stage 5: q^3 partial products
  logic [QW-1:0]  q5_q;
  logic [Q2W-1:0] plo5_q, phi5_q;
  logic [NSW-1:0] nasq5_q;
  logic [SQW-1:0] dxsq5_q, dysq5_q;
  side_t          side5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q5_q    <= q4_q;
      plo5_q  <= Q2W'(qq4_q[QW-1:0]) * Q2W'(q4_q);
      phi5_q  <= Q2W'(qq4_q[Q2W-1:QW]) * Q2W'(q4_q);
      nasq5_q <= nasq4_q;
      dxsq5_q <= dxsq4_q;
      dysq5_q <= dysq4_q;
      side5_q <= side4_q;
    end
  end

  // stage 6: q^3
  logic [QW-1:0]  q6_q;
  logic [Q3W-1:0] qc6_q;
  logic [NSW-1:0] nasq6_q;
  logic [SQW-1:0] dxsq6_q, dysq6_q;
  side_t          side6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q6_q    <= q5_q;
      qc6_q   <= Q3W'(plo5_q) + (Q3W'(phi5_q) << QW);
      nasq6_q <= nasq5_q;
      dxsq6_q <= dxsq5_q;
      dysq6_q <= dysq5_q;
      side6_q <= side5_q;
    end
  end

  // dividers and roots
  logic [Q3W-1:0]       k_hi;
  side_t                side6;
  logic [TAN_QW-1:0]    tqx, tqy;
  logic [CURV_QW-1:0]   kq;
  logic [TAN_IW/2-1:0]  trx, try_r;
  logic [CURV_QW/2-1:0] kr;
  logic [SOW-1:0]       sr;

  assign k_hi = Q3W'(nasq6_q[NSW-1:CURV_LO]);

  always_comb begin
    side6     = side6_q;
    side6.sat = (k_hi >= qc6_q);
  end

  tpc_div #(.DW(QW), .QW(TAN_QW)) u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_hi_i (QW'(dxsq6_q[SQW-1:1])),
    .num_lo_i ({dxsq6_q[0], {TAN_SH{1'b0}}}),
    .den_i    (q6_q),
    .quo_o    (tqx)
  );

  tpc_div #(.DW(QW), .QW(TAN_QW)) u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_hi_i (QW'(dysq6_q[SQW-1:1])),
    .num_lo_i ({dysq6_q[0], {TAN_SH{1'b0}}}),
    .den_i    (q6_q),
    .quo_o    (tqy)
  );

  tpc_div #(.DW(Q3W), .QW(CURV_QW)) u_div_k (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_hi_i (k_hi),
    .num_lo_i ({nasq6_q[CURV_LO-1:0], {CURV_SH{1'b0}}}),
    .den_i    (qc6_q),
    .quo_o    (kq)
  );

  tpc_isqrt #(.IW(TAN_IW)) u_sqrt_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  ({1'b0, tqx}),
    .root_o (trx)
  );

  tpc_isqrt #(.IW(TAN_IW)) u_sqrt_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  ({1'b0, tqy}),
    .root_o (try_r)
  );

  tpc_isqrt #(.IW(CURV_QW)) u_sqrt_k (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (kq),
    .root_o (kr)
  );

  tpc_isqrt #(.IW(SIW)) u_sqrt_s (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (SIW'(q6_q)),
    .root_o (sr)
  );

  // alignment delays
  logic [TAN_IW-1:0] tdl_q [TAN_DLY];
  logic [SOW-1:0]    sdl_q [STP_DLY];
  side_t             wdl_q [BODY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdl_q[0] <= {trx, try_r};
      for (int i = 1; i < TAN_DLY; i++) begin
        tdl_q[i] <= tdl_q[i-1];
      end
      sdl_q[0] <= sr;
      for (int i = 1; i < STP_DLY; i++) begin
        sdl_q[i] <= sdl_q[i-1];
      end
      wdl_q[0] <= side6;
      for (int i = 1; i < BODY; i++) begin
        wdl_q[i] <= wdl_q[i-1];
      end
    end
  end

  // final stage: rounding, sign, saturation and zeroing of degenerate items
  side_t              sd;
  logic [TAN_W-1:0]   tmx, tmy;
  logic [CURV_W-1:0]  kmag, kval;
  logic [STEP_W-1:0]  step;

  assign sd   = wdl_q[BODY-1];
  assign tmx  = TAN_W'(({1'b0, tdl_q[TAN_DLY-1][TAN_IW-1:TAN_IW/2]} + 17'd1) >> 1);
  assign tmy  = TAN_W'(({1'b0, tdl_q[TAN_DLY-1][TAN_IW/2-1:0]} + 17'd1) >> 1);
  assign kmag = sd.sat ? CURV_NEG_MAG : CURV_W'(({1'b0, kr} + 33'd1) >> 1);
  assign step = STEP_W'(({1'b0, sdl_q[STP_DLY-1]} + (SOW + 1)'(1)) >> 1);

  always_comb begin
    if (sd.neg_k) begin
      kval = -kmag;
    end else begin
      kval = kmag[CURV_W-1] ? CURV_POS_MAX : kmag;
    end
  end

  logic signed [FIELD_W-1:0] pos_x_q, pos_y_q;
  logic signed [TAN_W-1:0]   tan_x_q, tan_y_q;
  logic signed [CURV_W-1:0]  curv_q;
  logic [STEP_W-1:0]         step_q;
  logic                      degen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q <= sd.pos_x;
      pos_y_q <= sd.pos_y;
      degen_q <= sd.zero;
      if (sd.zero) begin
        tan_x_q <= '0;
        tan_y_q <= '0;
        curv_q  <= '0;
        step_q  <= '0;
      end else begin
        tan_x_q <= sd.neg_x ? -tmx : tmx;
        tan_y_q <= sd.neg_y ? -tmy : tmy;
        curv_q  <= kval;
        step_q  <= step;
      end
    end
  end

  assign out_o.valid       = vld_q[LAT-1];
  assign out_o.pos_x       = pos_x_q;
  assign out_o.pos_y       = pos_y_q;
  assign out_o.tan_x       = tan_x_q;
  assign out_o.tan_y       = tan_y_q;
  assign out_o.curvature   = curv_q;
  assign out_o.step_length = step_q;
  assign out_o.degenerate  = degen_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench of the three point tangent and curvature unit, scoreboard against a bit exact predictor
`default_nettype none

typedef struct {
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] tan_x;
  logic [15:0] tan_y;
  logic [31:0] curvature;
  logic [15:0] step_length;
  logic        degenerate;
} tpc_result_t;

class tpc_scoreboard;
  tpc_result_t pending[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  function automatic logic [15:0] tangent_round(logic [255:0] d, logic [255:0] q);
    logic [255:0] rhs;
    logic [255:0] n;
    logic [255:0] cand;
    logic [255:0] m;
    rhs = (d * d) << 30;
    n = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = n | (256'd1 << b);
      m = 2 * cand - 1;
      if (m * m * q <= rhs) n = cand;
    end
    return n[15:0];
  endfunction

  function automatic logic [32:0] curvature_round(logic [255:0] na, logic [255:0] q);
    logic [255:0] s;
    logic [255:0] rhs;
    logic [255:0] n;
    logic [255:0] cand;
    logic [255:0] m;
    s = na << 23;
    rhs = s * s;
    n = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = n | (256'd1 << b);
      m = 2 * cand - 1;
      if (m * q * m * q * q <= rhs) n = cand;
    end
    return n[32:0];
  endfunction

  function automatic logic [255:0] floor_root(logic [255:0] q);
    logic [255:0] r;
    logic [255:0] cand;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      cand = r | (256'd1 << b);
      if (cand * cand <= q) r = cand;
    end
    return r;
  endfunction

  function void note_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                          logic [15:0] by, logic [15:0] cx, logic [15:0] cy);
    tpc_result_t e;
    logic signed [63:0] dx2, dy2, ddx, ddy, num;
    logic [255:0] dxa, dya, q, na;
    logic [15:0] tx, ty;
    logic [32:0] k;
    dx2 = 64'($signed(cx)) - 64'($signed(ax));
    dy2 = 64'($signed(cy)) - 64'($signed(ay));
    ddx = 64'($signed(ax)) - 2 * 64'($signed(bx)) + 64'($signed(cx));
    ddy = 64'($signed(ay)) - 2 * 64'($signed(by)) + 64'($signed(cy));
    num = dx2 * ddy - dy2 * ddx;
    dxa = 256'(dx2 < 0 ? -dx2 : dx2);
    dya = 256'(dy2 < 0 ? -dy2 : dy2);
    na = 256'(num < 0 ? -num : num);
    q = dxa * dxa + dya * dya;
    e.pos_x = bx;
    e.pos_y = by;
    if (q == 0) begin
      e.tan_x = 0;
      e.tan_y = 0;
      e.curvature = 0;
      e.step_length = 0;
      e.degenerate = 1'b1;
    end else begin
      tx = tangent_round(dxa, q);
      ty = tangent_round(dya, q);
      k = curvature_round(na, q);
      e.tan_x = dx2 < 0 ? -tx : tx;
      e.tan_y = dy2 < 0 ? -ty : ty;
      if (num < 0) begin
        if (k > 33'h0_8000_0000) k = 33'h0_8000_0000;
        e.curvature = -k[31:0];
      end else begin
        if (k > 33'h0_7FFF_FFFF) k = 33'h0_7FFF_FFFF;
        e.curvature = k[31:0];
      end
      e.step_length = 16'((floor_root(q) + 1) >> 1);
      e.degenerate = 1'b0;
    end
    pending.push_back(e);
  endfunction

  function void check_result(tpc_result_t a);
    tpc_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing expected, pos %h %h", $time, a.pos_x, a.pos_y);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.pos_x !== e.pos_x) begin
      $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, a.pos_x); errors++;
    end
    if (a.pos_y !== e.pos_y) begin
      $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, a.pos_y); errors++;
    end
    if (a.tan_x !== e.tan_x) begin
      $display("%0t: tan_x expected %h actual %h", $time, e.tan_x, a.tan_x); errors++;
    end
    if (a.tan_y !== e.tan_y) begin
      $display("%0t: tan_y expected %h actual %h", $time, e.tan_y, a.tan_y); errors++;
    end
    if (a.curvature !== e.curvature) begin
      $display("%0t: curvature expected %h actual %h", $time, e.curvature, a.curvature);
      errors++;
    end
    if (a.step_length !== e.step_length) begin
      $display("%0t: step_length expected %h actual %h", $time, e.step_length,
               a.step_length);
      errors++;
    end
    if (a.degenerate !== e.degenerate) begin
      $display("%0t: degenerate expected %b actual %b", $time, e.degenerate, a.degenerate);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit rx_hold;
  tpc_scoreboard sb;

  tpc_in_if in_if ();
  tpc_out_if out_if ();

  three_point_tangent_curvature_unit u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #400000;
    $display("[three_point_tangent_curvature_unit] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    if (rx_hold) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    tpc_result_t r;
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_item(in_if.a_x, in_if.a_y, in_if.b_x, in_if.b_y, in_if.c_x, in_if.c_y);
    if (rst_n && out_if.valid && out_if.ready) begin
      r.pos_x = out_if.pos_x;
      r.pos_y = out_if.pos_y;
      r.tan_x = out_if.tan_x;
      r.tan_y = out_if.tan_y;
      r.curvature = out_if.curvature;
      r.step_length = out_if.step_length;
      r.degenerate = out_if.degenerate;
      sb.check_result(r);
    end
  end

  // called at a falling edge, returns at a falling edge after the item is taken
  task automatic send_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                           logic [15:0] by, logic [15:0] cx, logic [15:0] cy);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.a_x <= ax;
    in_if.a_y <= ay;
    in_if.b_x <= bx;
    in_if.b_y <= by;
    in_if.c_x <= cx;
    in_if.c_y <= cy;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] cx0, cy0;
    int unsigned span;
    if ($urandom_range(0, 3) == 0) begin
      send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
    end else begin
      cx0 = 16'($urandom);
      cy0 = 16'($urandom);
      span = 1 << $urandom_range(0, 9);
      send_item(cx0 + 16'($urandom_range(0, 2 * span) - span),
                cy0 + 16'($urandom_range(0, 2 * span) - span),
                cx0, cy0,
                cx0 + 16'($urandom_range(0, 2 * span) - span),
                cy0 + 16'($urandom_range(0, 2 * span) - span));
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    tx_idle_pct = 25;
    rx_idle_pct = 76;
    rx_hold = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.a_x = 0; in_if.a_y = 0; in_if.b_x = 0;
    in_if.b_y = 0; in_if.c_x = 0; in_if.c_y = 0;
    out_if.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // degenerate and extreme cases
    send_item(0, 0, 0, 0, 0, 0);
    send_item(16'h1234, 16'h8000, 16'h7FFF, 16'h8000, 16'h1234, 16'h8000);
    send_item(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_item(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
    send_item(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_item(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
    send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(0, 0, 16'd1, 16'd2, 16'd2, 16'd4);
    send_item(0, 0, 16'd8, 16'd0, 16'd16, 16'd0);
    send_item(0, 0, 0, 16'h7FFF, 16'd1, 0);
    send_item(0, 0, 0, 16'h8000, 16'd1, 0);
    send_item(0, 0, 16'h7FFF, 0, 0, 16'd1);
    send_item(0, 0, 16'h8000, 0, 0, 16'd1);
    send_item(0, 0, 16'd100, 16'd5, 16'd1, 16'd1);
    send_item(0, 0, 16'd1, 0, 16'd1, 16'd1);
    send_item(16'd10, 16'd10, 16'd11, 16'd11, 16'd10, 16'd12);
    send_item(16'd10, 16'd12, 16'd11, 16'd11, 16'd10, 16'd10);
    send_item(16'h7FFF, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(16'd3, 16'hFFFD, 16'd0, 16'd0, 16'hFFFD, 16'd3);

    for (int i = 0; i < 450; i++) send_random();
    tx_idle_pct = 76;
    rx_idle_pct = 25;
    for (int i = 0; i < 450; i++) send_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // long receiver stall while items keep coming
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 200; i++) send_random();
    join
    in_if.valid <= 1'b0;
    @(negedge clk);
    drain();
    for (int i = 0; i < 250; i++) send_random();
    in_if.valid <= 1'b0;

    drain();
    repeat (120) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[three_point_tangent_curvature_unit] OK");
    else
      $display("[three_point_tangent_curvature_unit] ERROR");
    $finish;
  end
endmodule

`default_nettype wire
